/* hw/rtl/expanding_width_escape_codec_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the expanding-width escape codec.
// Each macro places one labeled concurrent assertion on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef EXPANDING_WIDTH_ESCAPE_CODEC_ASSERT_SVH
`define EXPANDING_WIDTH_ESCAPE_CODEC_ASSERT_SVH

`ifndef SYNTH
// Assertion that is switched off while reset is high.
`define EWEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ewec assertion failed");
// Assertion that also holds during reset.
`define EWEC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("ewec assertion failed");
`else
`define EWEC_ASSERT(lbl, clk, rst, prop)
`define EWEC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/ewec_pkg.sv */
// ----------------------------------------------------------------------------
// ewec_pkg
// Types, constants and width helpers shared by the codec modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ewec_pkg;

   localparam int MAX_FIELD_BITS = 31;
   localparam int RUN_LIMIT      = 32;
   localparam int CODE_W         = 31;
   localparam int WIDTH_W        = 5;
   localparam int SUM_W          = 32;

   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   localparam logic CSR_LEAD_WIDTH = 1'b0;
   localparam logic CSR_GROW_STEP  = 1'b1;

   localparam logic [WIDTH_W-1:0] LEAD_WIDTH_RESET = 5'd4;
   localparam logic [WIDTH_W-1:0] GROW_STEP_RESET  = 5'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ENC,
      S_DEC
   } state_type;

   typedef struct packed {
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
      logic             sub;
   } alu_req_type;

   function automatic logic [WIDTH_W-1:0] first_width(input logic [WIDTH_W-1:0] init);
      logic [WIDTH_W-1:0] w;
      w = init;
      if (w == '0) begin
         w = 5'd1;
      end
      if (w > WIDTH_W'(MAX_FIELD_BITS)) begin
         w = WIDTH_W'(MAX_FIELD_BITS);
      end
      return w;
   endfunction

   function automatic logic [WIDTH_W-1:0] next_width(input logic [WIDTH_W-1:0] w,
                                                     input logic [WIDTH_W-1:0] step);
      logic [WIDTH_W-1:0] s;
      logic [WIDTH_W:0]   t;
      s = (step == '0) ? 5'd1 : step;
      t = {1'b0, w} + {1'b0, s};
      if (t > (WIDTH_W+1)'(MAX_FIELD_BITS)) begin
         t = (WIDTH_W+1)'(MAX_FIELD_BITS);
      end
      return t[WIDTH_W-1:0];
   endfunction

   function automatic logic [CODE_W-1:0] mask_of(input logic [WIDTH_W-1:0] w);
      logic [SUM_W-1:0] m;
      m = (SUM_W'(1) << w) - SUM_W'(1);
      return m[CODE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ewec_alu.sv */
// ----------------------------------------------------------------------------
// ewec_alu
// Shared 33-bit adder/subtractor used for escape compares and running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module ewec_alu (
   input  wire ewec_pkg::alu_req_type        req,
   output logic [ewec_pkg::SUM_W:0]          result
);

   logic [ewec_pkg::SUM_W-1:0] b_op;

   // For subtraction the top bit is the carry out, high when a >= b.
   assign b_op   = req.sub ? ~req.b : req.b;
   assign result = {1'b0, req.a} + {1'b0, b_op}
                 + {{ewec_pkg::SUM_W{1'b0}}, req.sub};

endmodule

`default_nettype wire

/* hw/rtl/expanding_width_escape_codec.sv */
// ----------------------------------------------------------------------------
// expanding_width_escape_codec
// Encoder and decoder for an escape code whose field widths grow per escape.
// ----------------------------------------------------------------------------
// An item arrives on the req_ stream: tuser is the action (encode or decode)
// and tdata holds the value to encode or the field just read. Results leave
// on the rsp_ stream through one output register.
// An encode item yields one transfer per field, the last one with tlast set.
// It is captured in S_IDLE and its fields, up to 32, are sent from S_ENC;
// the shared subtractor tests one escape per cycle while the output is free.
// A decode item yields one transfer; tdata then carries the next width to
// read and, with tuser set, the completed saturated value.
// The block takes a new item only while its sequencer is idle.
// When the receiver stalls, the sequencer holds until the output register
// frees; the held transfer stays unchanged.
// Synchronous reset empties the output, clears the decoder state and loads
// a first field width of 4 and a width step of 1. Registers are written
// through csr_; the user must do so only while idle, as the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module expanding_width_escape_codec (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [4:0]  csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // data_in[30:0], zero pad[31]
   input  wire         req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // field_code[30:0], field_width[35:31],
                                    // decoded_value[67:36], zero pad[71:68]
   output logic        rsp_tlast,   // last_field
   output logic        rsp_tuser    // value_done
);

   `include "expanding_width_escape_codec_assert.svh"

   localparam int CW = ewec_pkg::CODE_W;
   localparam int WW = ewec_pkg::WIDTH_W;
   localparam int SW = ewec_pkg::SUM_W;

   ewec_pkg::state_type state_ff, state_in;

   logic [WW-1:0] lead_width_ff, grow_step_ff;
   logic [CW-1:0] work_ff, work_in;
   logic [WW-1:0] enc_width_ff, enc_width_in;
   logic [WW-1:0] enc_count_ff, enc_count_in;
   logic [WW-1:0] dec_width_ff, dec_width_in;
   logic [SW-1:0] dec_sum_ff, dec_sum_in;
   logic          dec_active_ff, dec_active_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] code_ff, code_in;
   logic [WW-1:0] width_ff, width_in;
   logic          last_ff, last_in;
   logic [SW-1:0] value_ff, value_in;
   logic          done_ff, done_in;
   logic          load;

   logic                  out_free;
   logic [WW-1:0]         first_w;
   logic [WW-1:0]         dec_start_width;
   logic [SW-1:0]         dec_start_sum;
   logic [WW-1:0]         cur_width;
   logic [CW-1:0]         cur_mask;
   logic [CW-1:0]         field;
   logic [SW-1:0]         sat_sum;
   ewec_pkg::alu_req_type alu_req;
   logic [SW:0]           alu_res;

   ewec_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   assign out_free        = !rsp_valid_ff || rsp_tready;
   assign first_w         = ewec_pkg::first_width(lead_width_ff);
   assign dec_start_width = dec_active_ff ? dec_width_ff : first_w;
   assign dec_start_sum   = dec_active_ff ? dec_sum_ff : '0;
   assign cur_width       = (state_ff == ewec_pkg::S_DEC) ? dec_start_width : enc_width_ff;
   assign cur_mask        = ewec_pkg::mask_of(cur_width);
   assign field           = work_ff & cur_mask;
   assign sat_sum         = alu_res[SW] ? {SW{1'b1}} : alu_res[SW-1:0];

   always_comb begin
      alu_req.sub = (state_ff != ewec_pkg::S_DEC);
      alu_req.a   = alu_req.sub ? {1'b0, work_ff} : dec_start_sum;
      alu_req.b   = alu_req.sub ? {1'b0, cur_mask} : {1'b0, field};
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      enc_width_in  = enc_width_ff;
      enc_count_in  = enc_count_ff;
      dec_width_in  = dec_width_ff;
      dec_sum_in    = dec_sum_ff;
      dec_active_in = dec_active_ff;
      req_tready    = 1'b0;
      load          = 1'b0;
      code_in       = '0;
      width_in      = enc_width_ff;
      last_in       = 1'b0;
      value_in      = '0;
      done_in       = 1'b0;
      unique case (state_ff)
         ewec_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               work_in = req_tdata[CW-1:0];
               if (req_tuser == ewec_pkg::ACT_DECODE) begin
                  state_in = ewec_pkg::S_DEC;
               end else begin
                  state_in     = ewec_pkg::S_ENC;
                  enc_width_in = first_w;
                  enc_count_in = '0;
               end
            end
         end
         ewec_pkg::S_ENC: begin
            if (out_free) begin
               load     = 1'b1;
               width_in = enc_width_ff;
               if (alu_res[SW]) begin
                  if (enc_count_ff == WW'(ewec_pkg::RUN_LIMIT - 1)) begin
                     code_in  = cur_mask - CW'(1);
                     last_in  = 1'b1;
                     state_in = ewec_pkg::S_IDLE;
                  end else begin
                     code_in      = cur_mask;
                     work_in      = alu_res[CW-1:0];
                     enc_width_in = ewec_pkg::next_width(enc_width_ff, grow_step_ff);
                     enc_count_in = enc_count_ff + WW'(1);
                  end
               end else begin
                  code_in  = work_ff;
                  last_in  = 1'b1;
                  state_in = ewec_pkg::S_IDLE;
               end
            end
         end
         ewec_pkg::S_DEC: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ewec_pkg::S_IDLE;
               if (field == cur_mask) begin
                  dec_sum_in    = sat_sum;
                  dec_width_in  = ewec_pkg::next_width(cur_width, grow_step_ff);
                  dec_active_in = 1'b1;
                  width_in      = dec_width_in;
               end else begin
                  dec_sum_in    = '0;
                  dec_width_in  = first_w;
                  dec_active_in = 1'b0;
                  width_in      = first_w;
                  value_in      = sat_sum;
                  done_in       = 1'b1;
               end
            end
         end
         default: begin
            state_in = ewec_pkg::S_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ewec_pkg::S_IDLE;
         lead_width_ff <= ewec_pkg::LEAD_WIDTH_RESET;
         grow_step_ff  <= ewec_pkg::GROW_STEP_RESET;
         dec_width_ff  <= ewec_pkg::first_width(ewec_pkg::LEAD_WIDTH_RESET);
         dec_sum_ff    <= '0;
         dec_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dec_width_ff  <= dec_width_in;
         dec_sum_ff    <= dec_sum_in;
         dec_active_ff <= dec_active_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == ewec_pkg::CSR_LEAD_WIDTH) begin
               lead_width_ff <= csr_wdata;
            end else begin
               grow_step_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      enc_width_ff <= enc_width_in;
      enc_count_ff <= enc_count_in;
      if (load) begin
         code_ff  <= code_in;
         width_ff <= width_in;
         last_ff  <= last_in;
         value_ff <= value_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, value_ff, width_ff, code_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

   `EWEC_ASSERT(a_last_ends_run, clock, reset,
      (state_ff == ewec_pkg::S_ENC && load && last_in) |=> (state_ff == ewec_pkg::S_IDLE))
   `EWEC_ASSERT(a_enc_width_grows, clock, reset,
      (state_ff == ewec_pkg::S_ENC && $past(state_ff) == ewec_pkg::S_ENC)
         |-> (enc_width_ff >= $past(enc_width_ff)))
   `EWEC_ASSERT(a_done_not_last, clock, reset,
      rsp_valid_ff |-> !(done_ff && last_ff))
   `EWEC_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!rsp_valid_ff && state_ff == ewec_pkg::S_IDLE))

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for expanding_width_escape_codec
// Drives encode and decode transfers on the request stream and checks every
// response transfer against a predictor of the escape code that runs in step
// with the block. It covers directed corner cases and random runs under
// several register settings, with random gaps on both streams and one long
// receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_MAX    = 15;
   localparam int PRESS_AT   = 60;
   localparam int HOLD_LEN   = 300;
   localparam int QUIET_MAX  = 2000;
   localparam int SETTLE     = 40;
   localparam int RAND_ITEMS = 37;

   typedef struct packed {
      logic        action;
      logic [30:0] data;
   } codec_item_type;

   typedef struct packed {
      logic [30:0] code;
      logic [4:0]  width;
      logic        last;
      logic [31:0] value;
      logic        done;
   } field_result_type;

   typedef field_result_type field_q_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [4:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   codec_item_type   pending_items[$];
   field_result_type awaited_fields[$];

   logic [4:0]  cfg_init = ewec_pkg::LEAD_WIDTH_RESET;
   logic [4:0]  cfg_step = ewec_pkg::GROW_STEP_RESET;
   logic [4:0]  dec_width = ewec_pkg::LEAD_WIDTH_RESET;
   logic [31:0] dec_sum = '0;
   logic        dec_active = 1'b0;

   logic idle_free = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   int   items_accepted = 0;
   int   quiet_cycles = 0;
   int   mismatch_count = 0;
   int   results_checked = 0;
   int   enc_items = 0;
   int   dec_items = 0;
   int   values_done = 0;
   int   settings_used = 1;

   expanding_width_escape_codec dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_in[30:0], zero pad[31]
      .req_tuser  (req_tuser),   // action[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // field_code[30:0], field_width[35:31],
                                 // decoded_value[67:36], zero pad[71:68]
      .rsp_tlast  (rsp_tlast),   // last_field
      .rsp_tuser  (rsp_tuser)    // value_done
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [4:0] lead_width(input logic [4:0] v);
      if (v == '0) begin
         return 5'd1;
      end
      if (int'(v) > ewec_pkg::MAX_FIELD_BITS) begin
         return 5'(ewec_pkg::MAX_FIELD_BITS);
      end
      return v;
   endfunction

   function automatic logic [4:0] widen(input logic [4:0] w);
      int s;
      int t;
      s = (cfg_step == '0) ? 1 : int'(cfg_step);
      t = int'(w) + s;
      if (t > ewec_pkg::MAX_FIELD_BITS) begin
         t = ewec_pkg::MAX_FIELD_BITS;
      end
      return 5'(t);
   endfunction

   function automatic logic [31:0] field_mask(input logic [4:0] w);
      return (32'd1 << w) - 32'd1;
   endfunction

   function automatic field_q_type encode_run(input logic [30:0] value);
      field_q_type      run;
      field_result_type f;
      logic [4:0]       w;
      logic [31:0]      m;
      logic [31:0]      rest;
      w = lead_width(cfg_init);
      m = field_mask(w);
      rest = {1'b0, value};
      while (rest >= m) begin
         f = '0;
         f.width = w;
         if (run.size() == ewec_pkg::RUN_LIMIT - 1) begin
            f.code = 31'(m - 32'd1);
            f.last = 1'b1;
            run.push_back(f);
            return run;
         end
         f.code = 31'(m);
         run.push_back(f);
         rest = rest - m;
         w = widen(w);
         m = field_mask(w);
      end
      f = '0;
      f.code = rest[30:0];
      f.width = w;
      f.last = 1'b1;
      run.push_back(f);
      return run;
   endfunction

   function automatic field_result_type decode_field(input logic [30:0] data);
      field_result_type r;
      logic [31:0]      m;
      logic [31:0]      f;
      logic [32:0]      s;
      if (!dec_active) begin
         dec_width = lead_width(cfg_init);
         dec_sum = '0;
      end
      m = field_mask(dec_width);
      f = {1'b0, data} & m;
      s = {1'b0, dec_sum} + {1'b0, f};
      dec_sum = s[32] ? '1 : s[31:0];
      r = '0;
      if (f == m) begin
         dec_width = widen(dec_width);
         dec_active = 1'b1;
         r.width = dec_width;
      end else begin
         r.value = dec_sum;
         r.done = 1'b1;
         dec_active = 1'b0;
         dec_sum = '0;
         dec_width = lead_width(cfg_init);
         r.width = dec_width;
      end
      return r;
   endfunction

   task automatic compute_fields(input logic action, input logic [30:0] data);
      field_q_type run;
      if (action == ewec_pkg::ACT_ENCODE) begin
         run = encode_run(data);
         foreach (run[i]) begin
            awaited_fields.push_back(run[i]);
         end
      end else begin
         awaited_fields.push_back(decode_field(data));
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("[%0t] mismatch in %s at response %0d: got 0x%0h, wanted 0x%0h",
               $realtime, what, results_checked, got, want);
   endtask

   task automatic check_response();
      field_result_type want;
      if (awaited_fields.size() == 0) begin
         report_mismatch("unexpected transfer", 32'(rsp_tdata[30:0]), '0);
         return;
      end
      want = awaited_fields.pop_front();
      if (want.done) begin
         values_done++;
      end
      if (rsp_tdata[30:0] != want.code) begin
         report_mismatch("field_code", 32'(rsp_tdata[30:0]), 32'(want.code));
      end
      if (rsp_tdata[35:31] != want.width) begin
         report_mismatch("field_width", 32'(rsp_tdata[35:31]), 32'(want.width));
      end
      if (rsp_tlast != want.last) begin
         report_mismatch("last_field", 32'(rsp_tlast), 32'(want.last));
      end
      if (rsp_tdata[67:36] != want.value) begin
         report_mismatch("decoded_value", rsp_tdata[67:36], want.value);
      end
      if (rsp_tuser != want.done) begin
         report_mismatch("value_done", 32'(rsp_tuser), 32'(want.done));
      end
   endtask

   // Request side: one transfer per item, with a random gap drawn after each unless idle_free is set.
   always @(posedge clock) begin
      codec_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            compute_fields(req_tuser, req_tdata[30:0]);
            items_accepted <= items_accepted + 1;
            if (req_tuser == ewec_pkg::ACT_ENCODE) begin
               enc_items++;
            end else begin
               dec_items++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nxt = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.action;
               req_tdata <= {1'b0, nxt.data};
               gap_left = idle_free ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stall after each transfer unless idle_free is set, plus the long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response();
            results_checked++;
            stall_left = idle_free ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && items_accepted == PRESS_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_item(input logic action, input logic [30:0] data);
      codec_item_type it;
      it.action = action;
      it.data = data;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_tvalid || awaited_fields.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ewec_pkg::CSR_LEAD_WIDTH) begin
         cfg_init = value;
      end else begin
         cfg_step = value;
      end
   endtask

   task automatic set_widths(input logic [4:0] init_v, input logic [4:0] step_v,
                             input logic no_idle);
      drain();
      write_csr(ewec_pkg::CSR_LEAD_WIDTH, init_v);
      write_csr(ewec_pkg::CSR_GROW_STEP, step_v);
      @(negedge clock);
      idle_free = no_idle;
      settings_used++;
   endtask

   function automatic logic [30:0] pick_value();
      logic [63:0] acc;
      logic [4:0]  w;
      int          n;
      int          k;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2, 3: begin
            // Land on or just below the sum of the first few escape masks.
            acc = '0;
            w = lead_width(cfg_init);
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               acc = acc + 64'(field_mask(w));
               w = widen(w);
            end
            if (acc > 64'h7FFF_FFFF) begin
               acc = 64'h7FFF_FFFF;
            end
            return 31'(acc - 64'($urandom_range(0, 1)));
         end
         default: begin
            k = $urandom_range(1, 31);
            return 31'($urandom) & 31'(field_mask(5'(k)));
         end
      endcase
   endfunction

   task automatic queue_random_items(input int count);
      field_q_type run;
      logic [30:0] data;
      int          added;
      int          r;
      added = 0;
      while (added < count) begin
         r = $urandom_range(0, 19);
         if (r < 8) begin
            push_item(ewec_pkg::ACT_ENCODE, pick_value());
            added++;
         end else if (r < 17) begin
            run = encode_run(pick_value());
            foreach (run[i]) begin
               if (added >= count) begin
                  break;
               end
               data = run[i].code;
               if ($urandom_range(0, 3) == 0) begin
                  data = data | (31'($urandom) & ~31'(field_mask(run[i].width)));
               end
               if ($urandom_range(0, 7) == 0) begin
                  push_item(ewec_pkg::ACT_ENCODE, pick_value());
                  added++;
               end
               push_item(ewec_pkg::ACT_DECODE, data);
               added++;
            end
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               push_item(ewec_pkg::ACT_DECODE, 31'($urandom));
            end else begin
               push_item(ewec_pkg::ACT_DECODE, 31'($urandom_range(0, 3)));
            end
            added++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset widths: 4 then +1 per escape.
      push_item(ewec_pkg::ACT_ENCODE, 31'd0);
      push_item(ewec_pkg::ACT_ENCODE, 31'd14);
      push_item(ewec_pkg::ACT_ENCODE, 31'd15);
      push_item(ewec_pkg::ACT_ENCODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_ENCODE, 31'h5555_5555);
      push_item(ewec_pkg::ACT_ENCODE, 31'h2AAA_AAAA);
      push_item(ewec_pkg::ACT_DECODE, 31'd15);
      push_item(ewec_pkg::ACT_ENCODE, 31'd100);
      push_item(ewec_pkg::ACT_DECODE, 31'd31);
      push_item(ewec_pkg::ACT_DECODE, 31'd5);
      push_item(ewec_pkg::ACT_DECODE, 31'h7FFF_FFF3);
      push_item(ewec_pkg::ACT_DECODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_DECODE, 31'h4000_0000);

      // Zero registers count as one bit.
      set_widths(5'd0, 5'd0, 1'b0);
      push_item(ewec_pkg::ACT_ENCODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_ENCODE, 31'd1);
      push_item(ewec_pkg::ACT_DECODE, 31'd1);
      push_item(ewec_pkg::ACT_DECODE, 31'd3);
      push_item(ewec_pkg::ACT_DECODE, 31'd0);

      // Widest fields: the sum saturates, and a value is left part way.
      set_widths(5'd31, 5'd31, 1'b0);
      push_item(ewec_pkg::ACT_ENCODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_ENCODE, 31'h7FFF_FFFE);
      push_item(ewec_pkg::ACT_DECODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_DECODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_DECODE, 31'h7FFF_FFFF);
      push_item(ewec_pkg::ACT_DECODE, 31'd1);
      push_item(ewec_pkg::ACT_DECODE, 31'h7FFF_FFFF);

      // The value in progress keeps its width across the register change.
      set_widths(5'd2, 5'd5, 1'b0);
      push_item(ewec_pkg::ACT_DECODE, 31'd3);
      push_item(ewec_pkg::ACT_DECODE, 31'd3);
      push_item(ewec_pkg::ACT_DECODE, 31'd0);

      set_widths(5'd4, 5'd1, 1'b0);
      queue_random_items(RAND_ITEMS);
      set_widths(5'd1, 5'd1, 1'b0);
      queue_random_items(RAND_ITEMS);
      set_widths(5'd31, 5'd31, 1'b1);
      queue_random_items(RAND_ITEMS);
      set_widths(5'd0, 5'd0, 1'b0);
      queue_random_items(RAND_ITEMS);
      set_widths(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 1'b0);
      queue_random_items(RAND_ITEMS);
      set_widths(5'd1, 5'd31, 1'b1);
      queue_random_items(RAND_ITEMS);
      set_widths(5'd31, 5'd1, 1'b0);
      queue_random_items(RAND_ITEMS);
      set_widths(5'($urandom_range(1, 8)), 5'($urandom_range(1, 4)), 1'b0);
      queue_random_items(RAND_ITEMS);

      drain();
      repeat (SETTLE) @(negedge clock);
      $display("Covered %0d encode and %0d decode transfers over %0d width settings,",
               enc_items, dec_items, settings_used);
      $display("checking %0d response transfers and %0d completed values.",
               results_checked, values_done);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/ewec_pkg.sv
hw/rtl/ewec_alu.sv
hw/rtl/expanding_width_escape_codec.sv
tb/testbench.sv
